/* design/bole_pkg.sv */
package bole_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;

    // request opcodes
    typedef enum logic [3:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_INSERT_AT  = 4'd2,
        OP_DEL_VALUE  = 4'd3,
        OP_POP_FRONT  = 4'd4,
        OP_POP_BACK   = 4'd5,
        OP_DEL_AT     = 4'd6,
        OP_GET_FRONT  = 4'd7,
        OP_GET_BACK   = 4'd8,
        OP_GET_AT     = 4'd9,
        OP_DUMP       = 4'd10
    } t_opcode;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_FULL     = 3'd4,
        ST_APPENDED = 3'd5
    } t_status;

    // entry memory access, one write and one read port
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr;
    } t_ram_req;

    // input word to stored word (sign extend or truncate)
    function automatic t_word to_word(logic [31:0] v);
        return t_word'($signed(v));
    endfunction

    // stored word to result data (low 32 bits)
    function automatic logic [31:0] to_data(t_word w);
        return 32'(w);
    endfunction

endpackage

/* design/bole_ram.sv */
module bole_ram (
    input  logic                i_clk,
    input  bole_pkg::t_ram_req  i_req,
    output bole_pkg::t_word     o_rdata
);

    bole_pkg::t_word mem [bole_pkg::CAPACITY];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_req.raddr];
    end

endmodule

/* design/bounded_ordered_list_engine_unit.sv */
// Ordered list of up to CAPACITY signed words held packed in one entry RAM
// plus a count. A request is taken when start is high and busy is low; busy
// is low again in the cycle that shows the last result, so the next request
// can be taken then. Results appear on o_* for one cycle each, marked by
// o_valid, and cannot be stalled. Each request walks the RAM by reading an
// entry and writing it back one slot over: refused or empty requests answer
// straight from idle; pushes to the back write the word at once, and reads
// wait on the registered RAM read; an insert moves entries up, top down, then
// writes the word; a delete captures the removed word, then moves entries down;
// a value search reads and compares one entry at a time; a dump gives one
// result per entry.
module bounded_ordered_list_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_opcode,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_data,
    output logic [6:0]  o_entry_count,
    output logic        o_is_empty,
    output logic        o_last
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INS_STEP = 11'b000_0000_0010,
        S_INS_WR   = 11'b000_0000_0100,
        S_SRCH_RD  = 11'b000_0000_1000,
        S_SRCH_CMP = 11'b000_0001_0000,
        S_DEL_CAP  = 11'b000_0010_0000,
        S_DEL_STEP = 11'b000_0100_0000,
        S_DEL_WR   = 11'b000_1000_0000,
        S_GET_WAIT = 11'b001_0000_0000,
        S_DUMP_RD  = 11'b010_0000_0000,
        S_DUMP_OUT = 11'b100_0000_0000
    } t_state;

    t_state              r_state, n_state;
    bole_pkg::t_cnt      r_count, n_count;
    bole_pkg::t_cnt      r_ptr, n_ptr;
    bole_pkg::t_cnt      r_idx, n_idx;
    bole_pkg::t_word     r_word, n_word;
    bole_pkg::t_status   r_status, n_status;
    logic                r_valid, n_valid;
    logic                r_last, n_last;
    bole_pkg::t_status   r_ostatus, n_ostatus;
    logic [31:0]         r_odata, n_odata;

    bole_pkg::t_ram_req  ram_req;
    bole_pkg::t_word     ram_rdata;
    bole_pkg::t_cnt      cnt_m1;
    bole_pkg::t_cnt      pos_m1;
    logic                pos_bad;
    logic                accept;

    bole_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rdata(ram_rdata)
    );

    assign accept  = start && !busy;
    assign cnt_m1  = r_count - 1'b1;
    assign pos_m1  = bole_pkg::t_cnt'(32'(i_position) - 32'd1);
    assign pos_bad = (i_position == 7'd0) || (32'(i_position) > 32'(r_count));

    // request sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_word    = r_word;
        n_status  = r_status;
        n_valid   = 1'b0;
        n_last    = 1'b1;
        n_ostatus = r_ostatus;
        n_odata   = r_odata;
        ram_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_word    = bole_pkg::to_word(i_value);
                    n_ptr     = '0;
                    n_ostatus = bole_pkg::ST_OK;
                    n_odata   = '0;
                    case (i_opcode)
                        bole_pkg::OP_PUSH_FRONT, bole_pkg::OP_PUSH_BACK,
                        bole_pkg::OP_INSERT_AT: begin
                            n_ptr    = r_count;
                            n_status = bole_pkg::ST_OK;
                            if (32'(r_count) >= bole_pkg::CAPACITY) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_FULL;
                            end else if (i_opcode == bole_pkg::OP_PUSH_FRONT) begin
                                n_idx   = '0;
                                n_state = S_INS_STEP;
                            end else if (i_opcode == bole_pkg::OP_PUSH_BACK) begin
                                n_idx   = r_count;
                                n_state = S_INS_STEP;
                            end else if (i_position == 7'd0) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_BADPOS;
                            end else if (i_position == 7'd1) begin
                                // position one is a plain push to the front
                                n_idx   = '0;
                                n_state = S_INS_STEP;
                            end else if (32'(i_position) > 32'(r_count)) begin
                                n_idx    = r_count;
                                n_status = bole_pkg::ST_APPENDED;
                                n_state  = S_INS_STEP;
                            end else begin
                                n_idx   = pos_m1;
                                n_state = S_INS_STEP;
                            end
                        end
                        bole_pkg::OP_DEL_VALUE: begin
                            if (r_count == '0) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SRCH_RD;
                            end
                        end
                        bole_pkg::OP_POP_FRONT, bole_pkg::OP_POP_BACK,
                        bole_pkg::OP_GET_FRONT, bole_pkg::OP_GET_BACK: begin
                            if (r_count == '0) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_EMPTY;
                            end else begin
                                if (i_opcode == bole_pkg::OP_POP_FRONT ||
                                    i_opcode == bole_pkg::OP_GET_FRONT) begin
                                    n_ptr = '0;
                                end else begin
                                    n_ptr = cnt_m1;
                                end
                                ram_req.raddr = bole_pkg::ADDR_W'(n_ptr);
                                if (i_opcode == bole_pkg::OP_POP_FRONT ||
                                    i_opcode == bole_pkg::OP_POP_BACK) begin
                                    n_state = S_DEL_CAP;
                                end else begin
                                    n_state = S_GET_WAIT;
                                end
                            end
                        end
                        bole_pkg::OP_DEL_AT, bole_pkg::OP_GET_AT: begin
                            if (r_count == '0) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_EMPTY;
                            end else if (pos_bad) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_BADPOS;
                            end else begin
                                n_ptr         = pos_m1;
                                ram_req.raddr = bole_pkg::ADDR_W'(pos_m1);
                                n_state = (i_opcode == bole_pkg::OP_DEL_AT) ?
                                          S_DEL_CAP : S_GET_WAIT;
                            end
                        end
                        bole_pkg::OP_DUMP: begin
                            if (r_count == '0) begin
                                n_valid   = 1'b1;
                                n_ostatus = bole_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DUMP_RD;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            // shift entries up one slot, top down, then drop the word in
            S_INS_STEP: begin
                if (r_ptr == r_idx) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = bole_pkg::ADDR_W'(r_idx);
                    ram_req.wdata = r_word;
                    n_count       = r_count + 1'b1;
                    n_valid       = 1'b1;
                    n_ostatus     = r_status;
                    n_odata       = '0;
                    n_state       = S_IDLE;
                end else begin
                    ram_req.raddr = bole_pkg::ADDR_W'(r_ptr - 1'b1);
                    n_state       = S_INS_WR;
                end
            end
            S_INS_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bole_pkg::ADDR_W'(r_ptr);
                ram_req.wdata = ram_rdata;
                n_ptr         = r_ptr - 1'b1;
                n_state       = S_INS_STEP;
            end

            // linear search for the first match
            S_SRCH_RD: begin
                ram_req.raddr = bole_pkg::ADDR_W'(r_ptr);
                n_state       = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (ram_rdata == r_word) begin
                    n_state = S_DEL_STEP;
                end else if (r_ptr + 1'b1 == r_count) begin
                    n_valid   = 1'b1;
                    n_ostatus = bole_pkg::ST_NOTFOUND;
                    n_odata   = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_SRCH_RD;
                end
            end

            // capture removed word, then close the gap bottom up
            S_DEL_CAP: begin
                n_word  = ram_rdata;
                n_state = S_DEL_STEP;
            end
            S_DEL_STEP: begin
                if (r_ptr == cnt_m1) begin
                    n_count   = cnt_m1;
                    n_valid   = 1'b1;
                    n_ostatus = bole_pkg::ST_OK;
                    n_odata   = bole_pkg::to_data(r_word);
                    n_state   = S_IDLE;
                end else begin
                    ram_req.raddr = bole_pkg::ADDR_W'(r_ptr + 1'b1);
                    n_state       = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bole_pkg::ADDR_W'(r_ptr);
                ram_req.wdata = ram_rdata;
                n_ptr         = r_ptr + 1'b1;
                n_state       = S_DEL_STEP;
            end

            S_GET_WAIT: begin
                n_valid   = 1'b1;
                n_ostatus = bole_pkg::ST_OK;
                n_odata   = bole_pkg::to_data(ram_rdata);
                n_state   = S_IDLE;
            end

            // dump: one result per entry
            S_DUMP_RD: begin
                ram_req.raddr = bole_pkg::ADDR_W'(r_ptr);
                n_state       = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                n_valid   = 1'b1;
                n_ostatus = bole_pkg::ST_OK;
                n_odata   = bole_pkg::to_data(ram_rdata);
                n_last    = (r_ptr == cnt_m1);
                if (r_ptr == cnt_m1) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_DUMP_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_idx     <= n_idx;
        r_word    <= n_word;
        r_status  <= n_status;
        r_last    <= n_last;
        r_ostatus <= n_ostatus;
        r_odata   <= n_odata;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_ostatus;
    assign o_data        = r_odata;
    assign o_entry_count = 7'(r_count);
    assign o_is_empty    = (r_count == '0);
    assign o_last        = r_last;

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= bole_pkg::CAPACITY)
        else $error("entry count above capacity");

    // a result on an empty list is always the final one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_last)
        else $error("empty result not marked last");

    // RAM is only written while a request is in progress
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> busy)
        else $error("entry write while idle");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) ||
                  r_count == $past(r_count) + 1'b1 ||
                  r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

endmodule

/* bench/tb_bounded_ordered_list_engine_unit.sv */
module tb_bounded_ordered_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX   = 13;
    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM   = 40;

    typedef struct {
        logic [3:0]  opcode;
        logic [31:0] value;
        logic [6:0]  position;
    } t_request;

    typedef struct {
        bole_pkg::t_status status;
        logic [31:0]       data;
        logic [6:0]        entry_count;
        logic              is_empty;
        logic              last;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_opcode = '0;
    logic [31:0] i_value = '0;
    logic [6:0]  i_position = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_data;
    logic [6:0]  o_entry_count;
    logic        o_is_empty;
    logic        o_last;

    bounded_ordered_list_engine_unit dut (.*);

    always #5 i_clk = ~i_clk;

    t_request        request_q[$];
    t_answer         answer_q[$];
    bole_pkg::t_word shadow_list[$];
    int              mismatches = 0;
    int              results_seen = 0;
    int              requests_sent = 0;
    int              quiet_cycles = 0;
    int              gap_left = 0;
    logic            busy_at_edge = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    function automatic void push_answer(bole_pkg::t_status st, bole_pkg::t_word w,
                                        logic lst);
        t_answer a;
        a.status = st;
        a.data = 32'(w);
        a.entry_count = 7'(shadow_list.size());
        a.is_empty = (shadow_list.size() == 0);
        a.last = lst;
        answer_q.push_back(a);
    endfunction

    // list model: expected answers for one accepted request
    function automatic void predict_list(t_request r);
        bole_pkg::t_word   w;
        bole_pkg::t_word   got;
        bole_pkg::t_status st;
        int                n;
        int                p;
        w = bole_pkg::t_word'($signed(r.value));
        got = '0;
        st = bole_pkg::ST_OK;
        n = shadow_list.size();
        p = int'(r.position);
        case (r.opcode)
            bole_pkg::OP_PUSH_FRONT, bole_pkg::OP_PUSH_BACK, bole_pkg::OP_INSERT_AT: begin
                if (n >= bole_pkg::CAPACITY) st = bole_pkg::ST_FULL;
                else if (r.opcode == bole_pkg::OP_PUSH_FRONT) shadow_list.push_front(w);
                else if (r.opcode == bole_pkg::OP_PUSH_BACK) shadow_list.push_back(w);
                else if (p == 0) st = bole_pkg::ST_BADPOS;
                else if (p > n) begin
                    shadow_list.push_back(w);
                    st = (p == 1) ? bole_pkg::ST_OK : bole_pkg::ST_APPENDED;
                end else shadow_list.insert(p - 1, w);
            end
            bole_pkg::OP_DEL_VALUE: begin
                if (n == 0) st = bole_pkg::ST_EMPTY;
                else begin
                    st = bole_pkg::ST_NOTFOUND;
                    for (int i = 0; i < n; i++) begin
                        if (shadow_list[i] == w) begin
                            got = shadow_list[i];
                            shadow_list.delete(i);
                            st = bole_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            bole_pkg::OP_POP_FRONT, bole_pkg::OP_POP_BACK,
            bole_pkg::OP_GET_FRONT, bole_pkg::OP_GET_BACK: begin
                if (n == 0) st = bole_pkg::ST_EMPTY;
                else begin
                    p = (r.opcode == bole_pkg::OP_POP_FRONT ||
                         r.opcode == bole_pkg::OP_GET_FRONT) ? 0 : n - 1;
                    got = shadow_list[p];
                    if (r.opcode == bole_pkg::OP_POP_FRONT ||
                        r.opcode == bole_pkg::OP_POP_BACK)
                        shadow_list.delete(p);
                end
            end
            bole_pkg::OP_DEL_AT, bole_pkg::OP_GET_AT: begin
                if (n == 0) st = bole_pkg::ST_EMPTY;
                else if (p == 0 || p > n) st = bole_pkg::ST_BADPOS;
                else begin
                    got = shadow_list[p - 1];
                    if (r.opcode == bole_pkg::OP_DEL_AT) shadow_list.delete(p - 1);
                end
            end
            bole_pkg::OP_DUMP: begin
                if (n == 0) push_answer(bole_pkg::ST_EMPTY, '0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_answer(bole_pkg::ST_OK, shadow_list[i], i == n - 1);
                return;
            end
            default: ;
        endcase
        push_answer(st, got, 1'b1);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 7));
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request make_request(int op, logic [31:0] v, int p);
        t_request r;
        r.opcode = 4'(op);
        r.value = v;
        r.position = 7'(p);
        return r;
    endfunction

    // driver: one transfer per start, random gap before each
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy_at_edge) begin
                start <= 1'b0;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            end else if (!start) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else if (request_q.size() > 0) begin
                    i_opcode <= request_q[0].opcode;
                    i_value <= request_q[0].value;
                    i_position <= request_q[0].position;
                    start <= 1'b1;
                end
            end
        end
    end

    // acceptance and result checks at the rising edge
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        busy_at_edge <= busy;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (start && !busy) begin
                predict_list(request_q.pop_front());
                requests_sent++;
                moved = 1'b1;
            end
            if (o_valid) begin
                t_answer a;
                moved = 1'b1;
                results_seen++;
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result", o_data, '0);
                end else begin
                    a = answer_q.pop_front();
                    if (o_status !== a.status)
                        report_mismatch("status", 32'(o_status), 32'(a.status));
                    if (o_data !== a.data) report_mismatch("data", o_data, a.data);
                    if (o_entry_count !== a.entry_count)
                        report_mismatch("entry_count", 32'(o_entry_count),
                                        32'(a.entry_count));
                    if (o_is_empty !== a.is_empty)
                        report_mismatch("is_empty", 32'(o_is_empty), 32'(a.is_empty));
                    if (o_last !== a.last)
                        report_mismatch("last", 32'(o_last), 32'(a.last));
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int op;
        int n_model;
        // directed part: empty list cases, extremes, every special case
        request_q.push_back(make_request(bole_pkg::OP_DUMP, 0, 0));
        request_q.push_back(make_request(bole_pkg::OP_POP_FRONT, 0, 0));
        request_q.push_back(make_request(bole_pkg::OP_GET_AT, 0, 1));
        request_q.push_back(make_request(bole_pkg::OP_DEL_VALUE, 5, 0));
        request_q.push_back(make_request(bole_pkg::OP_INSERT_AT, 32'h8000_0000, 0));
        request_q.push_back(make_request(bole_pkg::OP_INSERT_AT, 32'h8000_0000, 1));
        request_q.push_back(make_request(bole_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 0));
        request_q.push_back(make_request(bole_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 0));
        request_q.push_back(make_request(bole_pkg::OP_INSERT_AT, 32'h5555_aaaa, 127));
        request_q.push_back(make_request(bole_pkg::OP_INSERT_AT, 32'h1234_5678, 2));
        request_q.push_back(make_request(bole_pkg::OP_GET_FRONT, 0, 0));
        request_q.push_back(make_request(bole_pkg::OP_GET_BACK, 0, 0));
        request_q.push_back(make_request(bole_pkg::OP_GET_AT, 0, 0));
        request_q.push_back(make_request(bole_pkg::OP_GET_AT, 0, 127));
        request_q.push_back(make_request(bole_pkg::OP_GET_AT, 0, 3));
        request_q.push_back(make_request(bole_pkg::OP_DEL_AT, 0, 2));
        request_q.push_back(make_request(bole_pkg::OP_DEL_AT, 0, 99));
        request_q.push_back(make_request(bole_pkg::OP_DEL_VALUE, 32'h7fff_ffff, 0));
        request_q.push_back(make_request(bole_pkg::OP_DEL_VALUE, 32'h0bad_0bad, 0));
        request_q.push_back(make_request(bole_pkg::OP_DUMP, 0, 0));
        request_q.push_back(make_request(bole_pkg::OP_POP_BACK, 0, 0));
        request_q.push_back(make_request(11, 32'hffff_ffff, 127));
        request_q.push_back(make_request(15, 0, 0));
        // fill to capacity, then refused inserts, a delete of the last entry and a dump
        for (int i = 0; i < bole_pkg::CAPACITY; i++)
            request_q.push_back(make_request(bole_pkg::OP_PUSH_BACK, rand_word(), 0));
        request_q.push_back(make_request(bole_pkg::OP_PUSH_FRONT, 1, 0));
        request_q.push_back(make_request(bole_pkg::OP_PUSH_BACK, 1, 0));
        request_q.push_back(make_request(bole_pkg::OP_INSERT_AT, 1, 5));
        request_q.push_back(make_request(bole_pkg::OP_DEL_AT, 0, bole_pkg::CAPACITY));
        request_q.push_back(make_request(bole_pkg::OP_DUMP, 0, 0));

        // random part, weighted toward inserts while the list is small
        n_model = bole_pkg::CAPACITY - 1;
        for (int i = 0; i < N_RANDOM; i++) begin
            op = $urandom_range(0, 15);
            if (op > 10 && $urandom_range(0, 3) != 0) op = $urandom_range(0, 2);
            if (n_model < 4 && $urandom_range(0, 1) == 1) op = $urandom_range(0, 2);
            if (op <= 2 && n_model < bole_pkg::CAPACITY) n_model++;
            else if (op >= 4 && op <= 6 && n_model > 0) n_model--;
            request_q.push_back(make_request(op, rand_word(),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, n_model + 1)));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (request_q.size() == 0 && !start);
        wait (answer_q.size() == 0);
        repeat (2 * bole_pkg::CAPACITY + 20) @(posedge i_clk);
        $display("ran %0d requests, checked %0d results, list held %0d at the end",
                 requests_sent, results_seen, shadow_list.size());
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
